// ----- hw/rtl/gph_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gph_pkg
// Shared types, field widths and constants of the lock-in gain/phase block.
// ----------------------------------------------------------------------------
package gph_pkg;

	localparam int IN_TDATA_W  = 176;
	localparam int IN_TUSER_W  = 2;
	localparam int OUT_TDATA_W = 80;

	localparam int MAG_W  = 24;
	localparam int PH_W   = 17;
	localparam int GAIN_W = 16;
	localparam int ACC_W  = 64;
	localparam int N_W    = 32;
	localparam int D_W    = 39;
	localparam int S_W    = 128;
	localparam int R_W    = 162;
	localparam int ROOT_W = 81;
	localparam int REM_W  = 83;
	localparam int X_W    = 34;
	localparam int Z_W    = 29;
	localparam int Y_W    = 31;
	localparam int L_W    = 21;
	localparam int WORD_W = 1 + PH_W + MAG_W;

	localparam int SQ_STEPS   = 6;
	localparam int SQRT_STEPS = 81;
	localparam int DIV_STEPS  = 24;
	localparam int LOG_STEPS  = 16;

	localparam logic [1:0] CMD_MEASURE = 2'd0;
	localparam logic [1:0] CMD_STORE   = 2'd1;
	localparam logic [1:0] CMD_CLEAR   = 2'd2;

	localparam logic signed [PH_W-1:0] PH_90  = 17'sd23040;
	localparam logic signed [PH_W-1:0] PH_180 = 17'sd46080;
	localparam logic signed [19:0]     DB_PER_OCT = 20'sd394566;

	typedef struct packed {
		logic load;
		logic sq_mul;
		logic sqrt_init;
		logic sqrt_step;
		logic div_init;
		logic div_step;
		logic norm_step;
		logic cord_init;
		logic cord_step;
		logic log_init;
		logic log_step;
		logic log_sel;
		logic log_keep;
		logic gain_mul;
		logic gain_rnd;
		logic finish;
		logic clr_wr;
	} ctl_cmd_t;

	typedef struct packed {
		logic norm_done;
		logic has;
		logic out_free;
		logic clear_cmd;
	} ctl_sts_t;

	// arctan(2^-i) in degrees, Q20
	function automatic logic [26:0] atan_q20(input logic [4:0] i);
		logic [26:0] v;
		case (i)
			5'd0:  v = 27'd47185920;
			5'd1:  v = 27'd27855475;
			5'd2:  v = 27'd14718068;
			5'd3:  v = 27'd7471121;
			5'd4:  v = 27'd3750058;
			5'd5:  v = 27'd1876857;
			5'd6:  v = 27'd938658;
			5'd7:  v = 27'd469357;
			5'd8:  v = 27'd234682;
			5'd9:  v = 27'd117342;
			5'd10: v = 27'd58671;
			5'd11: v = 27'd29335;
			5'd12: v = 27'd14668;
			5'd13: v = 27'd7334;
			5'd14: v = 27'd3667;
			5'd15: v = 27'd1833;
			5'd16: v = 27'd917;
			5'd17: v = 27'd458;
			5'd18: v = 27'd229;
			5'd19: v = 27'd115;
			5'd20: v = 27'd57;
			5'd21: v = 27'd29;
			5'd22: v = 27'd14;
			5'd23: v = 27'd7;
			5'd24: v = 27'd4;
			5'd25: v = 27'd2;
			5'd26: v = 27'd1;
			default: v = 27'd0;
		endcase
		return v;
	endfunction

endpackage

// ----- hw/rtl/gph_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gph_ctrl
// Sequencer: walks one result through square, root, divide, normalize, cordic
// and, with a baseline, log and gain; sweeps the baseline table on clear.
// ----------------------------------------------------------------------------
module gph_ctrl #(
	parameter int POINT_SLOTS  = 64,
	parameter int CORDIC_STEPS = 24
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  gph_pkg::ctl_sts_t   sts,
	output gph_pkg::ctl_cmd_t   cmd,
	output logic [((($clog2(POINT_SLOTS)) > 7) ? $clog2(POINT_SLOTS) : 7)-1:0] step
);

	localparam int IDX_W = $clog2(POINT_SLOTS);
	localparam int CNT_W = (IDX_W > 7) ? IDX_W : 7;

	localparam logic [3:0] S_CLR  = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_SQ   = 4'd2;
	localparam logic [3:0] S_SQRT = 4'd3;
	localparam logic [3:0] S_DIV  = 4'd4;
	localparam logic [3:0] S_NORM = 4'd5;
	localparam logic [3:0] S_CORD = 4'd6;
	localparam logic [3:0] S_LOGA = 4'd7;
	localparam logic [3:0] S_LOGB = 4'd8;
	localparam logic [3:0] S_GAIN = 4'd9;
	localparam logic [3:0] S_FIN  = 4'd10;

	logic [3:0]       state_q, state_d;
	logic [CNT_W-1:0] step_q, step_d;
	logic             first;

	assign step  = step_q;
	assign first = (step_q == '0);

	always_comb begin
		state_d  = state_q;
		step_d   = step_q + CNT_W'(1);
		cmd      = '0;
		in_ready = (state_q == S_IDLE);
		unique case (state_q)
			S_CLR: begin
				cmd.clr_wr = 1'b1;
				if (step_q == CNT_W'(POINT_SLOTS - 1)) begin
					state_d = S_IDLE;
					step_d  = '0;
				end
			end
			S_IDLE: begin
				step_d = '0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_SQ;
				end
			end
			S_SQ: begin
				cmd.sq_mul = (step_q < CNT_W'(gph_pkg::SQ_STEPS));
				if (step_q == CNT_W'(gph_pkg::SQ_STEPS)) begin
					state_d = S_SQRT;
					step_d  = '0;
				end
			end
			S_SQRT: begin
				cmd.sqrt_init = first;
				cmd.sqrt_step = !first;
				if (step_q == CNT_W'(gph_pkg::SQRT_STEPS)) begin
					state_d = S_DIV;
					step_d  = '0;
				end
			end
			S_DIV: begin
				cmd.div_init = first;
				cmd.div_step = !first;
				if (step_q == CNT_W'(gph_pkg::DIV_STEPS)) begin
					state_d = S_NORM;
					step_d  = '0;
				end
			end
			S_NORM: begin
				step_d = '0;
				cmd.norm_step = !sts.norm_done;
				if (sts.norm_done) begin
					state_d = S_CORD;
				end
			end
			S_CORD: begin
				cmd.cord_init = first;
				cmd.cord_step = !first;
				if (step_q == CNT_W'(CORDIC_STEPS)) begin
					state_d = sts.has ? S_LOGA : S_FIN;
					step_d  = '0;
				end
			end
			S_LOGA: begin
				cmd.log_init = first;
				cmd.log_step = !first;
				if (step_q == CNT_W'(gph_pkg::LOG_STEPS)) begin
					state_d = S_LOGB;
					step_d  = '0;
				end
			end
			S_LOGB: begin
				cmd.log_sel  = 1'b1;
				cmd.log_keep = first;
				cmd.log_init = first;
				cmd.log_step = !first;
				if (step_q == CNT_W'(gph_pkg::LOG_STEPS)) begin
					state_d = S_GAIN;
					step_d  = '0;
				end
			end
			S_GAIN: begin
				cmd.gain_mul = first;
				cmd.gain_rnd = !first;
				if (!first) begin
					state_d = S_FIN;
					step_d  = '0;
				end
			end
			S_FIN: begin
				step_d = '0;
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = sts.clear_cmd ? S_CLR : S_IDLE;
				end
			end
			default: begin
				state_d = S_CLR;
				step_d  = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	a_no_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> !in_ready)
		else $error("input taken twice in a row");

	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> sts.out_free)
		else $error("result loaded over a pending transfer");

	a_sqrt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SQRT) |-> (step_q <= CNT_W'(gph_pkg::SQRT_STEPS)))
		else $error("root step count overran");

endmodule

// ----- hw/rtl/gph_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gph_dp
// Datapath: squares, digit root, divider, cordic, log2, baseline table and
// the output register.
// ----------------------------------------------------------------------------
module gph_dp #(
	parameter int POINT_SLOTS = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  gph_pkg::ctl_cmd_t                   cmd,
	input  logic [((($clog2(POINT_SLOTS)) > 7) ? $clog2(POINT_SLOTS) : 7)-1:0] step,
	input  logic [gph_pkg::IN_TDATA_W-1:0]      in_data,
	input  logic [gph_pkg::IN_TUSER_W-1:0]      in_user,
	output gph_pkg::ctl_sts_t                   sts,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [gph_pkg::OUT_TDATA_W-1:0]     out_data
);

	localparam int IDX_W = $clog2(POINT_SLOTS);
	localparam int CNT_W = (IDX_W > 7) ? IDX_W : 7;
	localparam int EXT_W = ((IDX_W > 6) ? IDX_W : 6) + 1;

	localparam logic [1:0] SH_0  = 2'd0;
	localparam logic [1:0] SH_33 = 2'd1;
	localparam logic [1:0] SH_64 = 2'd2;

	// input fields
	logic [5:0]                    f_idx;
	logic [gph_pkg::ACC_W-1:0]     f_i, f_q;
	logic [gph_pkg::N_W-1:0]       f_n;
	logic [EXT_W-1:0]              idx_ext;

	assign f_idx   = in_data[5:0];
	assign f_i     = in_data[69:6];
	assign f_q     = in_data[133:70];
	assign f_n     = in_data[165:134];
	assign idx_ext = EXT_W'(f_idx);

	// per-item registers
	logic [1:0]                    cmd_q;
	logic [IDX_W-1:0]              idx_q;
	logic                          in_range_q, fault_q, neg_i_q, neg_q_q, zero_q;
	logic [gph_pkg::ACC_W-1:0]     a_q, b_q;
	logic [gph_pkg::D_W-1:0]       d_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q      <= in_user;
			idx_q      <= idx_ext[IDX_W-1:0];
			in_range_q <= (idx_ext < EXT_W'(POINT_SLOTS));
			fault_q    <= |in_data[169:166];
			neg_i_q    <= f_i[63];
			neg_q_q    <= f_q[63];
			a_q        <= f_i[63] ? (~f_i + 64'd1) : f_i;
			b_q        <= f_q[63] ? (~f_q + 64'd1) : f_q;
			zero_q     <= (f_n == '0);
			d_q        <= {f_n, 7'b0} - {7'b0, f_n};
		end else if (cmd.norm_step) begin
			a_q <= a_q >> 1;
			b_q <= b_q >> 1;
		end
	end

	// baseline table
	logic [gph_pkg::WORD_W-1:0]    base_mem_q [POINT_SLOTS];
	logic [gph_pkg::WORD_W-1:0]    rd_q;
	logic [gph_pkg::MAG_W-1:0]     base_mag;
	logic [gph_pkg::PH_W-1:0]      base_ph;
	logic                          base_vld;
	logic                          store_ok;
	logic [gph_pkg::MAG_W-1:0]     mag_w;
	logic signed [gph_pkg::PH_W-1:0] ph_w;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rd_q <= base_mem_q[idx_ext[IDX_W-1:0]];
		end
		if (cmd.clr_wr) begin
			base_mem_q[step[IDX_W-1:0]] <= '0;
		end else if (cmd.finish && store_ok) begin
			base_mem_q[idx_q] <= {1'b1, ph_w, mag_w};
		end
	end

	assign base_mag = rd_q[23:0];
	assign base_ph  = rd_q[40:24];
	assign base_vld = rd_q[41];

	// sum of squares, one 32x32 partial product per cycle
	logic [31:0]                   mx, my;
	logic [1:0]                    msh, sh_s1;
	logic [63:0]                   p_s1;
	logic                          pv_s1;
	logic [gph_pkg::S_W-1:0]       s_q, term;

	always_comb begin
		case (step[2:0])
			3'd0: begin mx = a_q[31:0];  my = a_q[31:0]; msh = SH_0;  end
			3'd1: begin mx = a_q[63:32]; my = a_q[31:0]; msh = SH_33; end
			3'd2: begin mx = a_q[63:32]; my = a_q[63:32]; msh = SH_64; end
			3'd3: begin mx = b_q[31:0];  my = b_q[31:0]; msh = SH_0;  end
			3'd4: begin mx = b_q[63:32]; my = b_q[31:0]; msh = SH_33; end
			3'd5: begin mx = b_q[63:32]; my = b_q[63:32]; msh = SH_64; end
			default: begin mx = '0; my = '0; msh = SH_0; end
		endcase
	end

	always_comb begin
		case (sh_s1)
			SH_33:   term = {31'b0, p_s1, 33'b0};
			SH_64:   term = {p_s1, 64'b0};
			default: term = {64'b0, p_s1};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_s1 <= 1'b0;
		end else begin
			pv_s1 <= cmd.sq_mul;
		end
	end

	always_ff @(posedge clk) begin
		p_s1  <= mx * my;
		sh_s1 <= msh;
		if (cmd.load) begin
			s_q <= '0;
		end else if (pv_s1) begin
			s_q <= s_q + term;
		end
	end

	// digit-by-digit square root of s * 2^34
	logic [gph_pkg::R_W-1:0]       r_sh_q;
	logic [gph_pkg::ROOT_W-1:0]    root_q;
	logic [gph_pkg::REM_W-1:0]     rem_q;
	logic [gph_pkg::REM_W+1:0]     rem_n, trial, rem_sub;
	logic                          rt_ge;

	assign rem_n   = {rem_q, r_sh_q[gph_pkg::R_W-1 -: 2]};
	assign trial   = {2'b0, root_q, 2'b01};
	assign rt_ge   = (rem_n >= trial);
	assign rem_sub = rem_n - trial;

	always_ff @(posedge clk) begin
		if (cmd.sqrt_init) begin
			r_sh_q <= {s_q, 34'b0};
			root_q <= '0;
			rem_q  <= '0;
		end else if (cmd.sqrt_step) begin
			r_sh_q <= r_sh_q << 2;
			root_q <= {root_q[gph_pkg::ROOT_W-2:0], rt_ge};
			rem_q  <= rt_ge ? rem_sub[gph_pkg::REM_W-1:0] : rem_n[gph_pkg::REM_W-1:0];
		end
	end

	// restoring divide by 127*n, 24 quotient bits
	logic [gph_pkg::ROOT_W-1:0]    dr_q;
	logic [61:0]                   dsh_q;
	logic [gph_pkg::MAG_W-1:0]     qt_q;
	logic                          sat_q, dv_ge;

	assign dv_ge = (dr_q >= {19'b0, dsh_q});

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			sat_q <= (root_q[80:24] >= {18'b0, d_q});
			dr_q  <= root_q;
			dsh_q <= {d_q, 23'b0};
			qt_q  <= '0;
		end else if (cmd.div_step) begin
			if (dv_ge) begin
				dr_q <= dr_q - {19'b0, dsh_q};
			end
			dsh_q <= dsh_q >> 1;
			qt_q  <= {qt_q[gph_pkg::MAG_W-2:0], dv_ge};
		end
	end

	assign mag_w = zero_q ? '0 : (sat_q ? {gph_pkg::MAG_W{1'b1}} : qt_q);

	// vectoring cordic
	logic signed [gph_pkg::X_W-1:0] x_q, y_q, dx, dy;
	logic signed [gph_pkg::Z_W-1:0] z_q, at_s, zr, thr;
	logic [CNT_W-1:0]              cm1;
	logic [4:0]                    ci;
	logic                          xz_q, yz_q;

	assign cm1  = step - CNT_W'(1);
	assign ci   = cm1[4:0];
	assign dx   = y_q >>> ci;
	assign dy   = x_q >>> ci;
	assign at_s = $signed({2'b00, gph_pkg::atan_q20(ci)});

	always_ff @(posedge clk) begin
		if (cmd.cord_init) begin
			x_q  <= $signed(a_q[gph_pkg::X_W-1:0]);
			y_q  <= $signed(b_q[gph_pkg::X_W-1:0]);
			z_q  <= '0;
			xz_q <= (a_q == '0);
			yz_q <= (b_q == '0);
		end else if (cmd.cord_step) begin
			if (y_q > 0) begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at_s;
			end else begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at_s;
			end
		end
	end

	logic signed [gph_pkg::PH_W-1:0] thc, thv, q1;

	assign zr  = z_q + 29'sd2048;
	assign thr = zr >>> 12;

	always_comb begin
		if (thr < 0) begin
			thc = '0;
		end else if (thr > 29'sd23040) begin
			thc = gph_pkg::PH_90;
		end else begin
			thc = thr[gph_pkg::PH_W-1:0];
		end
		if (yz_q) begin
			thv = '0;
		end else if (xz_q) begin
			thv = gph_pkg::PH_90;
		end else begin
			thv = thc;
		end
		q1   = neg_i_q ? (gph_pkg::PH_180 - thv) : thv;
		ph_w = zero_q ? '0 : (neg_q_q ? -q1 : q1);
	end

	// baseline use
	logic usable_w, has_w;

	assign usable_w = !fault_q && !zero_q && (mag_w != '0);
	assign has_w    = usable_w && (cmd_q != gph_pkg::CMD_STORE) &&
		(cmd_q != gph_pkg::CMD_CLEAR) && in_range_q && base_vld && (base_mag != '0);
	assign store_ok = (cmd_q == gph_pkg::CMD_STORE) && usable_w && in_range_q;

	// log2 by repeated squaring of the mantissa
	logic [gph_pkg::MAG_W-1:0]     lsrc;
	logic [4:0]                    le, e_q;
	logic [gph_pkg::Y_W-1:0]       lext, ly_q;
	logic [61:0]                   lp;
	logic [31:0]                   lyy;
	logic [15:0]                   frac_q;
	logic [gph_pkg::L_W-1:0]       la_q;

	assign lsrc = cmd.log_sel ? base_mag : mag_w;
	assign lext = {7'b0, lsrc};
	assign lp   = ly_q * ly_q;
	assign lyy  = lp[61:30];

	always_comb begin
		le = '0;
		for (int k = 0; k < gph_pkg::MAG_W; k++) begin
			if (lsrc[k]) begin
				le = 5'(k);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.log_keep) begin
			la_q <= {e_q, frac_q};
		end
		if (cmd.log_init) begin
			e_q    <= le;
			ly_q   <= lext << (5'd30 - le);
			frac_q <= '0;
		end else if (cmd.log_step) begin
			if (lyy[31]) begin
				ly_q   <= lyy[31:1];
				frac_q <= {frac_q[14:0], 1'b1};
			end else begin
				ly_q   <= lyy[30:0];
				frac_q <= {frac_q[14:0], 1'b0};
			end
		end
	end

	// gain in dB
	logic signed [21:0]            dl;
	logic signed [41:0]            gp_s1, gr;
	logic signed [gph_pkg::GAIN_W-1:0] gain_q;

	assign dl = $signed({1'b0, la_q}) - $signed({1'b0, e_q, frac_q});
	assign gr = (gp_s1 + 42'sd8388608) >>> 24;

	always_ff @(posedge clk) begin
		if (cmd.gain_mul) begin
			gp_s1 <= dl * gph_pkg::DB_PER_OCT;
		end
		if (cmd.gain_rnd) begin
			if (gr > 42'sd32767) begin
				gain_q <= 16'sh7fff;
			end else if (gr < -42'sd32768) begin
				gain_q <= 16'sh8000;
			end else begin
				gain_q <= gr[gph_pkg::GAIN_W-1:0];
			end
		end
	end

	// phase against baseline, wrapped
	logic signed [17:0] rdf;
	logic signed [17:0] rdw;

	assign rdf = $signed({ph_w[16], ph_w}) - $signed({base_ph[16], base_ph});

	always_comb begin
		if (rdf > 18'sd46080) begin
			rdw = rdf - 18'sd92160;
		end else if (rdf <= -18'sd46080) begin
			rdw = rdf + 18'sd92160;
		end else begin
			rdw = rdf;
		end
	end

	// output register
	logic                          out_vld_q;
	logic [gph_pkg::OUT_TDATA_W-1:0] out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.finish) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_q <= {2'b0,
				has_w ? rdw[16:0] : 17'd0,
				has_w ? gain_q : 16'sd0,
				has_w, store_ok, usable_w, zero_q, ph_w, mag_w};
		end
	end

	assign out_valid     = out_vld_q;
	assign out_data      = out_q;
	assign sts.norm_done = (a_q[63:30] == '0) && (b_q[63:30] == '0);
	assign sts.has       = has_w;
	assign sts.out_free  = !out_vld_q || out_ready;
	assign sts.clear_cmd = (cmd_q == gph_pkg::CMD_CLEAR);

	a_cord_normed: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cord_init |-> ((a_q[63:30] == '0) && (b_q[63:30] == '0)))
		else $error("cordic started on unnormalized operands");

	a_wr_excl: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_wr |-> !cmd.finish)
		else $error("clear sweep and store write collide");

	a_out_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_vld_q)
		else $error("finished result not presented");

endmodule

// ----- hw/rtl/iq_result_to_gain_phase.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iq_result_to_gain_phase
// Lock-in I/Q result to magnitude, phase and gain/phase against a baseline.
// ----------------------------------------------------------------------------
// One lock-in result enters on the s_axis channel, one result leaves on the
// m_axis channel for each transfer taken. The item is worked on serially:
// squares, square root, divide, operand normalize (shifting until the larger
// of |I| and |Q| fits), cordic, and loading the output register. A measure
// with a stored baseline adds the two log2 passes and the gain multiply
// before the load. The next item can be taken in the cycle after the result
// is loaded; no new item is taken while one is still being worked on.
// A clear command sweeps the baseline table after its result is loaded,
// during which no input is taken; the same sweep runs after reset before
// s_axis_tready first rises. The output register holds a result while the
// receiver stalls; a further result waits in the datapath until it is
// taken, and input stays blocked meanwhile.
// ----------------------------------------------------------------------------
module iq_result_to_gain_phase #(
	parameter int POINT_SLOTS  = 64,
	parameter int CORDIC_STEPS = 24
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// point_index, i_sum, q_sum, sample_total, overflow_flag, clip_flag,
	// low_signal_flag, setup_error_flag, zero pad
	input  logic [gph_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	// command
	input  logic [gph_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// magnitude, phase, zero_samples, usable, stored, has_baseline,
	// rel_gain_db, rel_phase, zero pad
	output logic [gph_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

	localparam int IDX_W = $clog2(POINT_SLOTS);
	localparam int CNT_W = (IDX_W > 7) ? IDX_W : 7;

	gph_pkg::ctl_cmd_t cmd;
	gph_pkg::ctl_sts_t sts;
	logic [CNT_W-1:0]  step;
	logic              rdy;

	assign s_axis_tready = rdy;

	gph_ctrl #(
		.POINT_SLOTS  (POINT_SLOTS),
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (rdy),
		.sts      (sts),
		.cmd      (cmd),
		.step     (step)
	);

	gph_dp #(
		.POINT_SLOTS (POINT_SLOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.step      (step),
		.in_data   (s_axis_tdata),
		.in_user   (s_axis_tuser),
		.sts       (sts),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule
